// ----- sv/vn3d_pkg.sv -----
package vn3d_pkg;

  // Default number of fraction bits of the component format.
  localparam int unsigned VN_FRAC_BITS = 16;

  // Threshold on the squared length after reset.
  localparam logic [63:0] VN_THR_RESET = 64'd512;

endpackage

// ----- sv/vector_normalize_3d.sv -----
// Each vector passes from the capture, squaring and sum stages through the bit-per-stage divider
// and square-root chains that run after the squaring stages, and then to the output register.
// Throughput: one vector per cycle; busy is low except during reset.
// Results appear for one cycle with done high; the receiver cannot stall.
// Reset clears every valid bit in the pipeline and loads the threshold with 512.
module vector_normalize_3d
  import vn3d_pkg::*;
#(
  parameter int unsigned FRAC_BITS = VN_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] x_in,
  input  logic signed [31:0] y_in,
  input  logic signed [31:0] z_in,
  input  logic               use_z,
  input  logic               cfg_write,
  input  logic        [63:0] cfg_data,
  output logic               done,
  output logic signed [31:0] x_out,
  output logic signed [31:0] y_out,
  output logic signed [31:0] z_out,
  output logic        [31:0] length,
  output logic               normalized
);

  // Quotient bits of the scaled-square division and result bits of its square root.
  localparam int unsigned QW = 2 * FRAC_BITS + 3;
  localparam int unsigned RW = FRAC_BITS + 2;
  localparam int unsigned CW = QW + 1;
  localparam int unsigned D  = (QW + RW > 32) ? (QW + RW) : 32;

  typedef struct packed {
    logic                  use_z;
    logic                  norm;
    logic [2:0][31:0]      raw;
    logic [2:0]            neg;
    logic [63:0]           s;
    logic [63:0]           lv;
    logic [63:0]           lr;
    logic [2:0][63:0]      dr;
    logic [2:0][QW-1:0]    dq;
    logic [2:0]            db;
    logic [2:0][CW-1:0]    cv;
    logic [2:0][CW-1:0]    cr;
  } stage_t;

  logic [63:0] thr;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= VN_THR_RESET;
    end else if (cfg_write) begin
      thr <= cfg_data;
    end
  end

  assign busy = rst;

  logic             acc;
  assign acc = start && !busy;

  // Stage 1: capture the vector and form the component magnitudes.
  logic             v1;
  logic             uz1;
  logic [2:0][31:0] raw1;
  logic [2:0][31:0] mag1;
  logic [2:0]       neg1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= acc;
    end
  end

  always_ff @(posedge clk) begin
    uz1     <= use_z;
    raw1[0] <= x_in;
    raw1[1] <= y_in;
    raw1[2] <= z_in;
    neg1[0] <= x_in[31];
    neg1[1] <= y_in[31];
    neg1[2] <= z_in[31];
    mag1[0] <= x_in[31] ? (~x_in + 32'd1) : x_in;
    mag1[1] <= y_in[31] ? (~y_in + 32'd1) : y_in;
    mag1[2] <= use_z ? (z_in[31] ? (~z_in + 32'd1) : z_in) : 32'd0;
  end

  // Stage 2: square each magnitude.
  logic             v2;
  logic             uz2;
  logic [2:0][31:0] raw2;
  logic [2:0]       neg2;
  logic [2:0][63:0] sq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    uz2  <= uz1;
    raw2 <= raw1;
    neg2 <= neg1;
    for (int j = 0; j < 3; j++) begin
      sq2[j] <= 64'(mag1[j]) * 64'(mag1[j]);
    end
  end

  // Stage 3: squared length.
  logic             v3;
  logic             uz3;
  logic [2:0][31:0] raw3;
  logic [2:0]       neg3;
  logic [2:0][63:0] sq3;
  logic [63:0]      sum3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    uz3  <= uz2;
    raw3 <= raw2;
    neg3 <= neg2;
    sq3  <= sq2;
    sum3 <= sq2[0] + sq2[1] + sq2[2];
  end

  // Iterative chain, one bit per stage: square-root bits of the length in the leading
  // stages, alongside quotient bits of each scaled square over the squared length,
  // then square-root bits of each quotient.
  stage_t     st [D+1];
  logic [D:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    st[0].use_z <= uz3;
    st[0].norm  <= (sum3 > thr);
    st[0].raw   <= raw3;
    st[0].neg   <= neg3;
    st[0].s     <= sum3;
    st[0].lv    <= sum3;
    st[0].lr    <= 64'd0;
    for (int j = 0; j < 3; j++) begin
      st[0].dr[j] <= {1'b0, sq3[j][63:1]};
      st[0].db[j] <= sq3[j][0];
      st[0].dq[j] <= '0;
      st[0].cv[j] <= '0;
      st[0].cr[j] <= '0;
    end
  end

  for (genvar k = 0; k < D; k++) begin : g_stage
    localparam int unsigned LSH = (k < 32) ? (62 - 2 * k) : 0;
    localparam int unsigned CI  = (k >= QW && k < QW + RW) ? (k - QW) : 0;
    localparam int unsigned CSH = 2 * (RW - 1 - CI);

    stage_t nx;

    always_comb begin
      logic [63:0]   lt;
      logic [64:0]   rr;
      logic [CW-1:0] cvs;
      logic [CW-1:0] crs;
      logic [CW-1:0] ct;
      nx  = st[k];
      lt  = '0;
      rr  = '0;
      cvs = '0;
      crs = '0;
      ct  = '0;
      // Length square root step.
      if (k < 32) begin
        lt = st[k].lr + (64'd1 << LSH);
        if (st[k].lv >= lt) begin
          nx.lv = st[k].lv - lt;
          nx.lr = (st[k].lr >> 1) + (64'd1 << LSH);
        end else begin
          nx.lr = st[k].lr >> 1;
        end
      end
      for (int j = 0; j < 3; j++) begin
        // Restoring division step.
        if (k < QW) begin
          rr = {st[k].dr[j], (k == 0) ? st[k].db[j] : 1'b0};
          if (rr >= {1'b0, st[k].s}) begin
            nx.dr[j] = 64'(rr - {1'b0, st[k].s});
            nx.dq[j] = {st[k].dq[j][QW-2:0], 1'b1};
          end else begin
            nx.dr[j] = rr[63:0];
            nx.dq[j] = {st[k].dq[j][QW-2:0], 1'b0};
          end
        end
        // Square root step on the quotient.
        if (k >= QW && k < QW + RW) begin
          cvs = (k == QW) ? {1'b0, st[k].dq[j]} : st[k].cv[j];
          crs = (k == QW) ? '0 : st[k].cr[j];
          ct  = crs + (CW'(1) << CSH);
          if (cvs >= ct) begin
            nx.cv[j] = cvs - ct;
            nx.cr[j] = (crs >> 1) + (CW'(1) << CSH);
          end else begin
            nx.cv[j] = cvs;
            nx.cr[j] = crs >> 1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      st[k+1] <= nx;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end
  end

  // Final rounding and sign restore.
  logic [31:0]      len_r;
  logic [2:0][31:0] comp_r;

  always_comb begin
    logic [RW:0] wp;
    wp    = '0;
    len_r = st[D].lr[31:0] + ((st[D].lv > st[D].lr) ? 32'd1 : 32'd0);
    for (int j = 0; j < 3; j++) begin
      wp        = {1'b0, st[D].cr[j][RW-1:0]} + (RW+1)'(1);
      comp_r[j] = 32'(wp[RW:1]);
      if (st[D].neg[j]) begin
        comp_r[j] = ~comp_r[j] + 32'd1;
      end
    end
  end

  // Output register; each result is shown for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[D];
    end
  end

  always_ff @(posedge clk) begin
    normalized <= st[D].norm;
    if (st[D].norm) begin
      x_out  <= comp_r[0];
      y_out  <= comp_r[1];
      z_out  <= st[D].use_z ? comp_r[2] : 32'd0;
      length <= len_r;
    end else begin
      x_out  <= st[D].raw[0];
      y_out  <= st[D].raw[1];
      z_out  <= st[D].use_z ? st[D].raw[2] : 32'd0;
      length <= 32'd0;
    end
  end

endmodule

// ----- sv/vn3d_checker.sv -----
module vn3d_checker
  import vn3d_pkg::*;
#(
  parameter int unsigned FRAC_BITS = VN_FRAC_BITS
) (
  input logic               clk,
  input logic               rst,
  input logic               done,
  input logic signed [31:0] x_out,
  input logic signed [31:0] y_out,
  input logic        [31:0] length,
  input logic               normalized
);

  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  // A transfer that skipped scaling reports zero length.
  a_skip_len: assert property (@(posedge clk) disable iff (rst)
    done && !normalized |-> length == 32'd0)
    else $error("skipped vector with nonzero length");

  // A scaled vector had a squared length of at least one, so its length is nonzero.
  a_norm_len: assert property (@(posedge clk) disable iff (rst)
    done && normalized |-> length != 32'd0)
    else $error("scaled vector with zero length");

  // The x and y unit components never exceed one in magnitude.
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    done && normalized |-> x_out <= ONE && x_out >= -ONE && y_out <= ONE && y_out >= -ONE)
    else $error("unit component out of range");

  // Reset empties the pipeline, so no result follows a reset cycle.
  a_reset_flush: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result right after reset");

endmodule

bind vector_normalize_3d vn3d_checker #(.FRAC_BITS(FRAC_BITS)) u_vn3d_checker (.*);
